### rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// shared defaults for the triangle unit normal block
// ----------------------------------------------------------------------------
package tun_pkg;
   localparam int COORD_BITS_DEF     = 16;
   localparam int NORM_FRAC_BITS_DEF = 15;
endpackage

### rtl/tun_req_if.sv
// ----------------------------------------------------------------------------
// tun_req_if
// triangle transaction channel: three vertices, valid/ready
// ----------------------------------------------------------------------------
interface tun_req_if #(
   parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
   logic signed [COORD_BITS-1:0] b_x, b_y, b_z;
   logic signed [COORD_BITS-1:0] c_x, c_y, c_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   output ready);
endinterface

### rtl/tun_rsp_if.sv
// ----------------------------------------------------------------------------
// tun_rsp_if
// unit normal transaction channel: Q1.F components and degenerate flag
// ----------------------------------------------------------------------------
interface tun_rsp_if #(
   parameter int NORM_FRAC_BITS = tun_pkg::NORM_FRAC_BITS_DEF
);
   logic                             valid;
   logic                             ready;
   logic signed [NORM_FRAC_BITS:0]   norm_x, norm_y, norm_z;
   logic                             degenerate;

   modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
   modport sink   (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

### rtl/triangle_unit_normal_core.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_core
// unit face normal of a triangle, exact cross product and exact truncated
// normalization by a pipelined bit-per-stage square-root quotient search
// ----------------------------------------------------------------------------
// One triangle enters per clock and one normal leaves per clock while the
// result register is not stalled. The path is six front stages (input,
// edges, products, cross product, squares, squared length) and then one stage
// per result bit, where all three components test their bit in parallel with
// one shift-add and compare each. The whole pipe holds while the result
// register is full and not taken, and req.ready is low only then.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core #(
   parameter int COORD_BITS     = tun_pkg::COORD_BITS_DEF,
   parameter int NORM_FRAC_BITS = tun_pkg::NORM_FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tun_req_if.sink   req,
   tun_rsp_if.source rsp
);
   localparam int C   = COORD_BITS;
   localparam int F   = NORM_FRAC_BITS;
   localparam int EW  = C + 1;
   localparam int PW  = 2 * EW;
   localparam int NW  = PW + 1;
   localparam int MW  = 2 * C + 2;
   localparam int SQW = 2 * MW;
   localparam int SW  = SQW + 2;
   localparam int LW  = SQW + 2 * F;
   localparam int QW  = F + 1;
   localparam int QSW = SW + QW;
   localparam int DW  = QSW + F + 1;

   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   // stage 0: input
   logic v0_ff;
   logic signed [C-1:0] in_ff [9];
   // stage 1: edges
   logic v1_ff;
   logic signed [EW-1:0] ed_ff [6];
   // stage 2: products
   logic v2_ff;
   logic signed [PW-1:0] pr_ff [6];
   // stage 3: cross product
   logic v3_ff;
   logic signed [NW-1:0] n_ff [3];
   // stage 4: squares
   logic v4_ff, dg4_ff;
   logic [SQW-1:0] sq_ff [3];
   logic [2:0] sg4_ff;
   // iteration stages, index 0 is the squared length stage
   logic           it_v_ff  [F+2];
   logic           it_dg_ff [F+2];
   logic [2:0]     it_sg_ff [F+2];
   logic [SW-1:0]  it_s_ff  [F+2];
   logic [LW-1:0]  it_r_ff  [F+2][3];
   logic [QW-1:0]  it_q_ff  [F+2][3];
   logic [QSW-1:0] it_qs_ff [F+2][3];

   logic signed [F:0] nx_ff, ny_ff, nz_ff;
   logic              dg_ff;

   logic signed [NW-1:0] mag_in [3];
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         mag_in[l] = n_ff[l][NW-1] ? -n_ff[l] : n_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         it_v_ff[0] <= 1'b0;
      end else if (en) begin
         v0_ff <= req.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         it_v_ff[0] <= v4_ff;
      end
      if (en) begin
         in_ff[0] <= req.a_x; in_ff[1] <= req.a_y; in_ff[2] <= req.a_z;
         in_ff[3] <= req.b_x; in_ff[4] <= req.b_y; in_ff[5] <= req.b_z;
         in_ff[6] <= req.c_x; in_ff[7] <= req.c_y; in_ff[8] <= req.c_z;
         for (int l = 0; l < 3; l++) begin
            ed_ff[l]     <= EW'(in_ff[3+l]) - EW'(in_ff[l]);
            ed_ff[3+l]   <= EW'(in_ff[6+l]) - EW'(in_ff[l]);
         end
         // ux=0 uy=1 uz=2 vx=3 vy=4 vz=5
         pr_ff[0] <= PW'(ed_ff[1]) * PW'(ed_ff[5]);
         pr_ff[1] <= PW'(ed_ff[2]) * PW'(ed_ff[4]);
         pr_ff[2] <= PW'(ed_ff[2]) * PW'(ed_ff[3]);
         pr_ff[3] <= PW'(ed_ff[0]) * PW'(ed_ff[5]);
         pr_ff[4] <= PW'(ed_ff[0]) * PW'(ed_ff[4]);
         pr_ff[5] <= PW'(ed_ff[1]) * PW'(ed_ff[3]);
         for (int l = 0; l < 3; l++) begin
            n_ff[l] <= NW'(pr_ff[2*l]) - NW'(pr_ff[2*l+1]);
         end
         for (int l = 0; l < 3; l++) begin
            sq_ff[l]  <= SQW'(MW'(mag_in[l])) * SQW'(MW'(mag_in[l]));
            sg4_ff[l] <= n_ff[l][NW-1];
         end
         dg4_ff <= (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
         it_s_ff[0]  <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
         it_sg_ff[0] <= sg4_ff;
         it_dg_ff[0] <= dg4_ff;
         for (int l = 0; l < 3; l++) begin
            it_r_ff[0][l]  <= LW'(sq_ff[l]) << (2 * F);
            it_q_ff[0][l]  <= '0;
            it_qs_ff[0][l] <= '0;
         end
      end
   end

   for (genvar j = 0; j <= F; j++) begin : g_bit
      localparam int K = F - j;
      logic [DW-1:0]  delta [3];
      logic           fit   [3];
      logic [DW-1:0]  rem   [3];
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            delta[l] = (DW'(it_qs_ff[j][l]) << (K + 1)) + (DW'(it_s_ff[j]) << (2 * K));
            fit[l]   = delta[l] <= DW'(it_r_ff[j][l]);
            rem[l]   = DW'(it_r_ff[j][l]) - delta[l];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            it_v_ff[j+1] <= 1'b0;
         end else if (en) begin
            it_v_ff[j+1] <= it_v_ff[j];
         end
         if (en) begin
            it_s_ff[j+1]  <= it_s_ff[j];
            it_sg_ff[j+1] <= it_sg_ff[j];
            it_dg_ff[j+1] <= it_dg_ff[j];
            for (int l = 0; l < 3; l++) begin
               if (fit[l]) begin
                  it_r_ff[j+1][l]  <= rem[l][LW-1:0];
                  it_q_ff[j+1][l]  <= it_q_ff[j][l] | (QW'(1) << K);
                  it_qs_ff[j+1][l] <= it_qs_ff[j][l] + (QSW'(it_s_ff[j]) << K);
               end else begin
                  it_r_ff[j+1][l]  <= it_r_ff[j][l];
                  it_q_ff[j+1][l]  <= it_q_ff[j][l];
                  it_qs_ff[j+1][l] <= it_qs_ff[j][l];
               end
            end
         end
      end
   end

   logic signed [F:0] comp [3];
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         logic [F-1:0] qs;
         qs = (it_q_ff[F+1][l][F]) ? {F{1'b1}} : it_q_ff[F+1][l][F-1:0];
         if (it_dg_ff[F+1]) begin
            comp[l] = '0;
         end else if (it_sg_ff[F+1][l]) begin
            comp[l] = -$signed({1'b0, qs});
         end else begin
            comp[l] = $signed({1'b0, qs});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= it_v_ff[F+1];
      end
      if (en) begin
         nx_ff <= comp[0];
         ny_ff <= comp[1];
         nz_ff <= comp[2];
         dg_ff <= it_dg_ff[F+1];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.norm_x     = nx_ff;
   assign rsp.norm_y     = ny_ff;
   assign rsp.norm_z     = nz_ff;
   assign rsp.degenerate = dg_ff;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dg_ff) |-> (nx_ff == '0 && ny_ff == '0 && nz_ff == '0))
      else $error("degenerate result with nonzero component");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (nx_ff != {1'b1, {F{1'b0}}} && ny_ff != {1'b1, {F{1'b0}}}
                        && nz_ff != {1'b1, {F{1'b0}}}))
      else $error("component outside saturation range");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(it_v_ff[0]) && $stable(v0_ff))
      else $error("pipeline moved during stall");
endmodule
